// ----- design/mclw_pkg.sv -----
// ----------------------------------------------------------------------------
// mclw_pkg
// types and codes shared by the liveness watchdog modules
// ----------------------------------------------------------------------------
package mclw_pkg;

   localparam logic [3:0] CMD_REGISTER  = 4'd0;
   localparam logic [3:0] CMD_SET_STATE = 4'd1;
   localparam logic [3:0] CMD_BEAT      = 4'd2;
   localparam logic [3:0] CMD_PROGRESS  = 4'd3;
   localparam logic [3:0] CMD_LOOP      = 4'd4;
   localparam logic [3:0] CMD_REPORT    = 4'd5;
   localparam logic [3:0] CMD_RUNTIME   = 4'd6;
   localparam logic [3:0] CMD_STOP      = 4'd7;
   localparam logic [3:0] CMD_TICK      = 4'd8;
   localparam logic [3:0] CMD_CHECK     = 4'd9;
   localparam logic [3:0] CMD_QUERY     = 4'd10;

   localparam logic [2:0] ST_INIT    = 3'd0;
   localparam logic [2:0] ST_RUNNING = 3'd2;
   localparam logic [2:0] ST_ERROR   = 3'd5;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_UNREG = 2'd1;
   localparam logic [1:0] STAT_DUP   = 2'd2;

   localparam logic [2:0] CAUSE_NONE     = 3'd0;
   localparam logic [2:0] CAUSE_SOFTWARE = 3'd1;
   localparam logic [2:0] CAUSE_BEAT     = 3'd2;
   localparam logic [2:0] CAUSE_PROGRESS = 3'd3;
   localparam logic [2:0] CAUSE_BOTH     = 3'd4;

   typedef struct packed {
      logic [3:0]  command;
      logic [2:0]  channel;
      logic        critical_flag;
      logic [31:0] heartbeat_limit;
      logic [31:0] progress_limit;
      logic [2:0]  new_state;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  channel_state;
      logic [31:0] loop_total;
      logic [31:0] error_total;
      logic [2:0]  failure_cause;
      logic        proc_fail;
      logic        proc_degraded;
      logic [2:0]  runtime_mode;
      logic        stop_flag;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture the command
      logic execute;   // apply a command other than check
      logic scan;      // check one channel at the scan pointer
      logic scan_init; // clear scan pointer and flags
      logic scan_done; // commit failed and degraded; a failure forces runtime error
      logic respond;   // drive the result
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic is_check;
      logic scan_last;
   } sts_type;

endpackage

// ----- design/mclw_ctrl.sv -----
// ----------------------------------------------------------------------------
// mclw_ctrl
// sequencer: load, execute or scan, respond
// ----------------------------------------------------------------------------
module mclw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mclw_pkg::sts_type sts,
   output mclw_pkg::ctl_type ctl
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DEC   = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_DONE  = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (sts.is_check) begin
               ctl.scan_init = 1'b1;
               state_in      = S_SCAN;
            end else begin
               ctl.execute = 1'b1;
               state_in    = S_RESP;
            end
         end
         S_SCAN: begin
            ctl.scan = 1'b1;
            if (sts.scan_last) state_in = S_DONE;
         end
         S_DONE: begin
            ctl.scan_done = 1'b1;
            state_in      = S_RESP;
         end
         S_RESP: begin
            ctl.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);

`ifndef SYNTH
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.load |-> state_ff == S_IDLE) else $error("load outside idle");
   a_resp_back: assert property (@(posedge clock) disable iff (reset)
      ctl.respond |=> !busy) else $error("no return to idle");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("item not taken");
`endif

endmodule

// ----- design/mclw_dp.sv -----
// ----------------------------------------------------------------------------
// mclw_dp
// channel tables, tick counter, scan unit and result register
// ----------------------------------------------------------------------------
module mclw_dp #(
   parameter int CHANNELS  = 8,
   parameter int TIME_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  mclw_pkg::ctl_type ctl,
   output mclw_pkg::sts_type sts,
   input  mclw_pkg::req_type req_data,
   output logic              rsp_valid,
   output mclw_pkg::rsp_type rsp_data
);

   localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   mclw_pkg::req_type cmd_ff;

   logic [CHANNELS-1:0]  valid_ff, crit_ff;
   logic [2:0]           state_ff [CHANNELS];
   logic [31:0]          blim_ff  [CHANNELS];
   logic [31:0]          plim_ff  [CHANNELS];
   logic [TIME_BITS-1:0] bstamp_ff[CHANNELS];
   logic [TIME_BITS-1:0] pstamp_ff[CHANNELS];
   logic [31:0]          loop_ff  [CHANNELS];
   logic [31:0]          err_ff   [CHANNELS];
   logic [2:0]           cause_ff [CHANNELS];

   logic [TIME_BITS-1:0] now_ff;
   logic [2:0]           runtime_ff;
   logic                 stop_ff, failed_ff, degraded_ff;
   logic                 sfail_ff, sdeg_ff;
   logic [IW-1:0]        ptr_ff;
   logic                 rsp_valid_ff;
   mclw_pkg::rsp_type    rsp_ff;
   logic                 dup_ff;

   // addressed channel
   logic          inrange, reg_ok, new_ok;
   logic [IW-1:0] idx;
   always_comb begin
      inrange = ({29'd0, cmd_ff.channel} < CHANNELS);
      idx     = inrange ? IW'(cmd_ff.channel) : '0;
      reg_ok  = inrange && valid_ff[idx];
      new_ok  = (cmd_ff.new_state <= mclw_pkg::ST_ERROR);
   end

   // scan of one channel
   logic [TIME_BITS-1:0] hb_age, pr_age;
   logic                 hb_late, pr_late, run_s, late, bad;
   always_comb begin
      hb_age  = now_ff - bstamp_ff[ptr_ff];
      pr_age  = now_ff - pstamp_ff[ptr_ff];
      hb_late = {{(64-TIME_BITS){1'b0}}, hb_age} > {32'd0, blim_ff[ptr_ff]};
      pr_late = {{(64-TIME_BITS){1'b0}}, pr_age} > {32'd0, plim_ff[ptr_ff]};
      run_s   = valid_ff[ptr_ff] && state_ff[ptr_ff] == mclw_pkg::ST_RUNNING;
      late    = run_s && (hb_late || pr_late);
      bad     = late || (valid_ff[ptr_ff] && state_ff[ptr_ff] == mclw_pkg::ST_ERROR);
   end

   assign sts.is_check  = (cmd_ff.command == mclw_pkg::CMD_CHECK);
   assign sts.scan_last = (ptr_ff == IW'(CHANNELS - 1));

   always_ff @(posedge clock) begin
      if (ctl.load) cmd_ff <= req_data;
   end

   // channel tables
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         crit_ff  <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            state_ff[i] <= mclw_pkg::ST_INIT;
            loop_ff[i]  <= '0;
            err_ff[i]   <= '0;
            cause_ff[i] <= mclw_pkg::CAUSE_NONE;
         end
      end else if (ctl.execute) begin
         case (cmd_ff.command)
            mclw_pkg::CMD_REGISTER: if (inrange && !reg_ok) begin
               valid_ff[idx]  <= 1'b1;
               crit_ff[idx]   <= cmd_ff.critical_flag;
               state_ff[idx]  <= mclw_pkg::ST_INIT;
               blim_ff[idx]   <= cmd_ff.heartbeat_limit;
               plim_ff[idx]   <= cmd_ff.progress_limit;
               bstamp_ff[idx] <= now_ff;
               pstamp_ff[idx] <= now_ff;
               loop_ff[idx]   <= '0;
               err_ff[idx]    <= '0;
               cause_ff[idx]  <= mclw_pkg::CAUSE_NONE;
            end
            mclw_pkg::CMD_SET_STATE: if (reg_ok && new_ok) state_ff[idx] <= cmd_ff.new_state;
            mclw_pkg::CMD_BEAT:     if (reg_ok) bstamp_ff[idx] <= now_ff;
            mclw_pkg::CMD_PROGRESS: if (reg_ok) pstamp_ff[idx] <= now_ff;
            mclw_pkg::CMD_LOOP:     if (reg_ok) loop_ff[idx] <= loop_ff[idx] + 32'd1;
            mclw_pkg::CMD_REPORT: if (reg_ok) begin
               err_ff[idx]   <= err_ff[idx] + 32'd1;
               cause_ff[idx] <= mclw_pkg::CAUSE_SOFTWARE;
            end
            default: ;
         endcase
      end else if (ctl.scan && late) begin
         state_ff[ptr_ff] <= mclw_pkg::ST_ERROR;
         err_ff[ptr_ff]   <= err_ff[ptr_ff] + 32'd1;
         cause_ff[ptr_ff] <= (hb_late && pr_late) ? mclw_pkg::CAUSE_BOTH :
                             hb_late ? mclw_pkg::CAUSE_BEAT : mclw_pkg::CAUSE_PROGRESS;
      end
   end

   // global registers and scan walker
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff      <= '0;
         runtime_ff  <= mclw_pkg::ST_INIT;
         stop_ff     <= 1'b0;
         failed_ff   <= 1'b0;
         degraded_ff <= 1'b0;
         sfail_ff    <= 1'b0;
         sdeg_ff     <= 1'b0;
         ptr_ff      <= '0;
      end else begin
         if (ctl.execute) begin
            case (cmd_ff.command)
               mclw_pkg::CMD_RUNTIME: if (new_ok) runtime_ff <= cmd_ff.new_state;
               mclw_pkg::CMD_STOP:    stop_ff <= 1'b1;
               mclw_pkg::CMD_TICK:    now_ff  <= now_ff + 1'b1;
               default: ;
            endcase
         end
         if (ctl.scan_init) begin
            ptr_ff   <= '0;
            sfail_ff <= 1'b0;
            sdeg_ff  <= 1'b0;
         end
         if (ctl.scan) begin
            if (!sts.scan_last) ptr_ff <= ptr_ff + 1'b1;
            if (bad && crit_ff[ptr_ff])  sfail_ff <= 1'b1;
            if (bad && !crit_ff[ptr_ff]) sdeg_ff  <= 1'b1;
         end
         if (ctl.scan_done) begin
            failed_ff   <= sfail_ff;
            degraded_ff <= sdeg_ff;
            if (sfail_ff) runtime_ff <= mclw_pkg::ST_ERROR;
         end
      end
   end

   // duplicate registration seen at execute time
   always_ff @(posedge clock) begin
      if (ctl.execute) dup_ff <= reg_ok;
      else if (ctl.scan_init) dup_ff <= 1'b0;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= ctl.respond;
      if (ctl.respond) begin
         if (cmd_ff.command == mclw_pkg::CMD_REGISTER && inrange && dup_ff)
            rsp_ff.status <= mclw_pkg::STAT_DUP;
         else
            rsp_ff.status <= reg_ok ? mclw_pkg::STAT_OK : mclw_pkg::STAT_UNREG;
         rsp_ff.channel_state <= reg_ok ? state_ff[idx] : mclw_pkg::ST_ERROR;
         rsp_ff.loop_total    <= reg_ok ? loop_ff[idx] : 32'd0;
         rsp_ff.error_total   <= reg_ok ? err_ff[idx] : 32'd0;
         rsp_ff.failure_cause <= reg_ok ? cause_ff[idx] : mclw_pkg::CAUSE_NONE;
         rsp_ff.proc_fail     <= failed_ff;
         rsp_ff.proc_degraded <= degraded_ff;
         rsp_ff.runtime_mode  <= runtime_ff;
         rsp_ff.stop_flag     <= stop_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      ctl.scan |-> {{(32-IW){1'b0}}, ptr_ff} < CHANNELS) else $error("scan pointer out of range");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(ctl.scan && ctl.execute)) else $error("scan and execute together");
   a_fail_rt: assert property (@(posedge clock) disable iff (reset)
      (ctl.scan_done && sfail_ff) |=> runtime_ff == mclw_pkg::ST_ERROR)
      else $error("failure did not force runtime error");
`endif

endmodule

// ----- design/multi_channel_liveness_watchdog.sv -----
// ----------------------------------------------------------------------------
// multi_channel_liveness_watchdog
// liveness watchdog over a set of monitored channels
// ----------------------------------------------------------------------------
// usage
//   a command item is taken when start is high and busy is low; req_data
//   carries the command, the channel and its arguments
//   each item gives exactly one result on rsp_data, shown for one cycle
//   with rsp_valid high; the receiver cannot stall it
// item flow
//   ordinary commands: decode, then respond; rsp_valid is registered from
//   the respond state, and no new item is taken until the sequencer is idle
//   check: the scan walks one channel a cycle through one heartbeat and
//   one progress age comparator, then commits the flags and responds
// reset
//   synchronous; no channel registered, all counters, time and flags zero
//   limit and stamp entries hold nothing until a channel registers
// ----------------------------------------------------------------------------
module multi_channel_liveness_watchdog #(
   parameter int CHANNELS  = 8,
   parameter int TIME_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mclw_pkg::req_type req_data,
   output logic              rsp_valid,
   output mclw_pkg::rsp_type rsp_data
);

   // command and status between sequencer and datapath
   mclw_pkg::ctl_type ctl;
   mclw_pkg::sts_type sts;

   mclw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   mclw_dp #(
      .CHANNELS  (CHANNELS),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
